### sv/gda_pkg.sv
// Shared types, constants and functions of the Gregorian date unit.
// No dependencies; imported by every module of the block.
package gda_pkg;

    // Operation codes
    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;

    localparam int YEAR_MAX_DEF = 9999;
    localparam int DIFF_LIMIT   = 4194303;

    // Serial day number width (signed, covers year 0 up to 16383)
    localparam int SW = 25;

    // Days in 400, 100, 4 and 1 year cycles
    localparam int CYC400 = 146097;
    localparam int CYC100 = 36524;
    localparam int CYC4   = 1461;
    localparam int CYC1   = 365;

    // Side data carried beside the date conversion stages
    typedef struct packed {
        logic        cmp;
        logic        oor;
        logic [22:0] diff;
        logic        gt;
        logic        eq;
    } side_t;

    // Days before the first of month m in a common year (m in 1..12)
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // Serial number of December 31 of year y (elaboration only)
    function automatic int last_serial(input int y);
        int p;
        int lp;
        p  = y - 1;
        lp = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        return 365 * p + p / 4 - p / 100 + p / 400 + 364 + lp;
    endfunction

endpackage

### sv/gda_serial.sv
// Two-stage conversion of a year/month/day date to a signed serial day number.
// Depends on gda_pkg.
module gda_serial import gda_pkg::*; (
    input  logic                 aclk,
    input  logic                 en0,
    input  logic                 en1,
    input  logic [13:0]          year,
    input  logic [3:0]           month,
    input  logic [4:0]           day,
    output logic signed [SW-1:0] serial
);

    logic        y0_reg;
    logic        y4_reg;
    logic [13:0] p_reg;
    logic [26:0] tp_reg;
    logic [24:0] tq_reg;
    logic [26:0] ty_reg;
    logic [3:0]  mon_reg;
    logic [4:0]  day_reg;
    logic [SW-1:0] serial_reg;

    logic [13:0] p;
    logic [3:0]  mon_c;
    logic [7:0]  q100p;
    logic [7:0]  q100y;
    logic [5:0]  q400;
    logic        leap;
    logic [SW-1:0] base;
    logic [SW-1:0] serial_next;

    // Clamp month, form year-1 and the reciprocal products for /100 and /400
    always_comb begin
        p = year - 14'd1;
        if (month == 4'd0) begin
            mon_c = 4'd1;
        end else if (month > 4'd12) begin
            mon_c = 4'd12;
        end else begin
            mon_c = month;
        end
    end

    always_ff @(posedge aclk) begin
        if (en0) begin
            y0_reg  <= (year == 14'd0);
            y4_reg  <= (year[1:0] == 2'b00);
            p_reg   <= p;
            tp_reg  <= 27'(p) * 27'd5243;
            tq_reg  <= 25'(p[13:2]) * 25'd5243;
            ty_reg  <= 27'(year) * 27'd5243;
            mon_reg <= mon_c;
            day_reg <= day;
        end
    end

    // Days before the year, days before the month, then the day
    always_comb begin
        q100p = tp_reg[26:19];
        q100y = ty_reg[26:19];
        q400  = tq_reg[24:19];
        leap  = y4_reg && ((q100p == q100y) || (q100y[1:0] == 2'b00));
        if (y0_reg) begin
            base = -SW'(366);
        end else begin
            base = SW'(p_reg) * SW'(365) + SW'(p_reg[13:2]) - SW'(q100p) + SW'(q400);
        end
        serial_next = base + SW'(cum_days(mon_reg))
                    + SW'(leap && (mon_reg > 4'd2)) + SW'(day_reg) - SW'(1);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            serial_reg <= serial_next;
        end
    end

    assign serial = $signed(serial_reg);

endmodule

### sv/gda_date.sv
// Eight-stage conversion of a serial day number back to year, month and day.
// Depends on gda_pkg.
module gda_date import gda_pkg::*; (
    input  logic        aclk,
    input  logic [7:0]  en,
    input  logic [22:0] n,
    output logic [13:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day
);

    logic [22:0] n0_reg, n1_reg;
    logic [35:0] t0_reg;
    logic [5:0]  q400_1_reg, q400_2_reg, q400_3_reg, q400_4_reg, q400_5_reg, q400_6_reg;
    logic [23:0] pr1_reg;
    logic [17:0] r2_reg;
    logic [1:0]  q100_3_reg, q100_4_reg, q100_5_reg, q100_6_reg;
    logic [15:0] rc3_reg, rc4_reg, rc5_reg;
    logic [26:0] t4_reg;
    logic [15:0] pr5_reg;
    logic [4:0]  q4_5_reg, q4_6_reg;
    logic [1:0]  q1_6_reg;
    logic [8:0]  r4_6_reg;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    logic [5:0]  q400_c;
    logic [23:0] r_c;
    logic [17:0] r_fix;
    logic [5:0]  q400_fix;
    logic [1:0]  q100_c;
    logic [17:0] sub100;
    logic [4:0]  q4_c;
    logic [15:0] r3_c;
    logic [15:0] r3_fix;
    logic [4:0]  q4_fix;
    logic [1:0]  q1_c;
    logic [10:0] sub1;
    logic        leap;
    logic [3:0]  mon_c;
    logic [8:0]  cl;
    logic [8:0]  cl_sel;

    // Estimate the 400-year count by a reciprocal product
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            n0_reg <= n;
            t0_reg <= 36'(n) * 36'd7349;
        end
    end

    // Multiply the estimate back
    assign q400_c = t0_reg[35:30];
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            n1_reg     <= n0_reg;
            q400_1_reg <= q400_c;
            pr1_reg    <= 24'(q400_c) * 24'(CYC400);
        end
    end

    // Form the remainder and correct an estimate one low
    always_comb begin
        r_c = 24'(n1_reg) - pr1_reg;
        if (r_c >= 24'(CYC400)) begin
            r_fix    = 18'(r_c - 24'(CYC400));
            q400_fix = q400_1_reg + 6'd1;
        end else begin
            r_fix    = 18'(r_c);
            q400_fix = q400_1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            r2_reg     <= r_fix;
            q400_2_reg <= q400_fix;
        end
    end

    // Century count by threshold compare, capped at three
    always_comb begin
        if (r2_reg >= 18'(3 * CYC100)) begin
            q100_c = 2'd3;
            sub100 = 18'(3 * CYC100);
        end else if (r2_reg >= 18'(2 * CYC100)) begin
            q100_c = 2'd2;
            sub100 = 18'(2 * CYC100);
        end else if (r2_reg >= 18'(CYC100)) begin
            q100_c = 2'd1;
            sub100 = 18'(CYC100);
        end else begin
            q100_c = 2'd0;
            sub100 = 18'd0;
        end
    end
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            q400_3_reg <= q400_2_reg;
            q100_3_reg <= q100_c;
            rc3_reg    <= 16'(r2_reg - sub100);
        end
    end

    // Estimate the 4-year count
    always_ff @(posedge aclk) begin
        if (en[4]) begin
            q400_4_reg <= q400_3_reg;
            q100_4_reg <= q100_3_reg;
            rc4_reg    <= rc3_reg;
            t4_reg     <= 27'(rc3_reg) * 27'd1435;
        end
    end

    assign q4_c = t4_reg[25:21];
    always_ff @(posedge aclk) begin
        if (en[5]) begin
            q400_5_reg <= q400_4_reg;
            q100_5_reg <= q100_4_reg;
            rc5_reg    <= rc4_reg;
            q4_5_reg   <= q4_c;
            pr5_reg    <= 16'(q4_c) * 16'(CYC4);
        end
    end

    // Correct the 4-year count, then take whole years capped at three
    always_comb begin
        r3_c = rc5_reg - pr5_reg;
        if (r3_c >= 16'(CYC4)) begin
            r3_fix = r3_c - 16'(CYC4);
            q4_fix = q4_5_reg + 5'd1;
        end else begin
            r3_fix = r3_c;
            q4_fix = q4_5_reg;
        end
        if (r3_fix >= 16'(3 * CYC1)) begin
            q1_c = 2'd3;
            sub1 = 11'(3 * CYC1);
        end else if (r3_fix >= 16'(2 * CYC1)) begin
            q1_c = 2'd2;
            sub1 = 11'(2 * CYC1);
        end else if (r3_fix >= 16'(CYC1)) begin
            q1_c = 2'd1;
            sub1 = 11'(CYC1);
        end else begin
            q1_c = 2'd0;
            sub1 = 11'd0;
        end
    end
    always_ff @(posedge aclk) begin
        if (en[6]) begin
            q400_6_reg <= q400_5_reg;
            q100_6_reg <= q100_5_reg;
            q4_6_reg   <= q4_fix;
            q1_6_reg   <= q1_c;
            r4_6_reg   <= 9'(r3_fix - 16'(sub1));
        end
    end

    // Assemble the year and search the month table
    always_comb begin
        leap   = (q1_6_reg == 2'd3) && ((q4_6_reg != 5'd24) || (q100_6_reg == 2'd3));
        mon_c  = 4'd1;
        cl_sel = 9'd0;
        for (int k = 2; k <= 12; k++) begin
            cl = cum_days(4'(k)) + 9'(leap && (k > 2));
            if (r4_6_reg >= cl) begin
                mon_c  = 4'(k);
                cl_sel = cl;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (en[7]) begin
            year_reg  <= 14'(16'(q400_6_reg) * 16'd400 + 16'(q100_6_reg) * 16'd100
                       + 16'(q4_6_reg) * 16'd4 + 16'(q1_6_reg) + 16'd1);
            month_reg <= mon_c;
            day_reg   <= 5'(r4_6_reg - cl_sel + 9'd1);
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

### sv/gregorian_date_arithmetic.sv
// Gregorian date unit: add/subtract a day offset or compare two dates.
// Accepts one item per cycle while the output is not stalled. The fully
// registered 11-stage pipeline collapses bubbles under output stall.
// aresetn (synchronous, active low) clears all stage valid bits.
// Depends on gda_pkg, gda_serial, gda_date.
module gregorian_date_arithmetic import gda_pkg::*; #(
    parameter int YEAR_MAX = YEAR_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func, a_year, a_month, a_day, b_year, b_month, b_day, offset (low bit up)
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // res_year, res_month, res_day, difference, a_greater, a_equal, out_of_range
    output logic [55:0] m_tdata
);

    localparam int NS = 11;
    localparam logic signed [SW-1:0] SERIAL_TOP = SW'(last_serial(YEAR_MAX));

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   en;

    logic [1:0]  func0_reg, func1_reg;
    logic [22:0] off0_reg, off1_reg;
    logic        gt0_reg, gt1_reg, eq0_reg, eq1_reg;

    logic [1:0]  in_func;
    logic [13:0] in_ay, in_by;
    logic [3:0]  in_am, in_bm;
    logic [4:0]  in_ad, in_bd;

    logic signed [SW-1:0] sa;
    logic signed [SW-1:0] sb;
    logic signed [SW-1:0] offx;
    logic signed [SW-1:0] nsum;
    logic signed [SW-1:0] dfull;
    logic [22:0] dsat;
    logic        cmp1;

    logic [22:0] n2_reg;
    side_t       side_reg [2:NS-1];
    side_t       side2;

    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    side_t       so;
    logic        res_kill;

    // Unpack the input item
    assign in_func = s_tdata[1:0];
    assign in_ay   = s_tdata[15:2];
    assign in_am   = s_tdata[19:16];
    assign in_ad   = s_tdata[24:20];
    assign in_by   = s_tdata[38:25];
    assign in_bm   = s_tdata[42:39];
    assign in_bd   = s_tdata[47:43];

    // Stage advance: a stage loads when empty or when its successor loads
    always_comb begin
        en[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k + 1];
        end
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                v_next[k] = (k == 0) ? s_tvalid : v_reg[(k == 0) ? 0 : k - 1];
            end else begin
                v_next[k] = v_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    // Operation, offset and lexicographic compare travel beside the serial units
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            func0_reg <= in_func;
            off0_reg  <= s_tdata[70:48];
            eq0_reg   <= (in_ay == in_by) && (in_am == in_bm) && (in_ad == in_bd);
            if (in_ay != in_by) begin
                gt0_reg <= in_ay > in_by;
            end else if (in_am != in_bm) begin
                gt0_reg <= in_am > in_bm;
            end else begin
                gt0_reg <= in_ad > in_bd;
            end
        end
        if (en[1]) begin
            func1_reg <= func0_reg;
            off1_reg  <= off0_reg;
            gt1_reg   <= gt0_reg;
            eq1_reg   <= eq0_reg;
        end
    end

    gda_serial u_serial_a (
        .aclk   (aclk),
        .en0    (en[0]),
        .en1    (en[1]),
        .year   (in_ay),
        .month  (in_am),
        .day    (in_ad),
        .serial (sa)
    );

    gda_serial u_serial_b (
        .aclk   (aclk),
        .en0    (en[0]),
        .en1    (en[1]),
        .year   (in_by),
        .month  (in_bm),
        .day    (in_bd),
        .serial (sb)
    );

    // Apply the offset, check range, form the saturated difference
    always_comb begin
        cmp1 = func1_reg[1];
        offx = SW'($signed(off1_reg));
        if (func1_reg == FUNC_ADD) begin
            nsum = sa + offx;
        end else begin
            nsum = sa - offx;
        end
        dfull = sa - sb;
        if (dfull > SW'(DIFF_LIMIT)) begin
            dsat = 23'(DIFF_LIMIT);
        end else if (dfull < -SW'(DIFF_LIMIT)) begin
            dsat = 23'(-DIFF_LIMIT);
        end else begin
            dsat = dfull[22:0];
        end
        side2.cmp  = cmp1;
        side2.oor  = !cmp1 && (nsum[SW-1] || (nsum > SERIAL_TOP));
        side2.diff = cmp1 ? dsat : 23'd0;
        side2.gt   = cmp1 && gt1_reg;
        side2.eq   = cmp1 && eq1_reg;
    end

    // Hold side data in step with the date conversion stages
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            n2_reg      <= nsum[22:0];
            side_reg[2] <= side2;
        end
        for (int k = 3; k < NS; k++) begin
            if (en[k]) begin
                side_reg[k] <= side_reg[k - 1];
            end
        end
    end

    gda_date u_date (
        .aclk  (aclk),
        .en    (en[NS-1:3]),
        .n     (n2_reg),
        .year  (r_year),
        .month (r_month),
        .day   (r_day)
    );

    // Drop the date fields for compare or out-of-range results
    always_comb begin
        so       = side_reg[NS-1];
        res_kill = so.cmp || so.oor;
        m_tdata  = {7'd0, so.oor, so.eq, so.gt, so.diff,
                    res_kill ? 5'd0 : r_day,
                    res_kill ? 4'd0 : r_month,
                    res_kill ? 14'd0 : r_year};
    end

`ifndef ASSERT_OFF
    a_oor_no_date: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[48]) |-> (m_tdata[22:0] == 23'd0))
        else $error("out-of-range result carries a date");
    a_gt_eq_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[46] && m_tdata[47]))
        else $error("greater and equal both set");
    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");
`endif

endmodule

### tb/sv/gregorian_date_arithmetic_tb.sv
// Testbench of the Gregorian date unit: directed and random items with a
// scoreboard that predicts each result. Depends on gda_pkg and the block.
module gregorian_date_arithmetic_tb import gda_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_CMP  = 2'd2;
    localparam logic [1:0] FUNC_CMP3 = 2'd3;
    localparam int LATENCY    = 11;
    localparam int CYCLE_STOP = 400000;
    localparam int N_RANDOM   = 750;

    typedef struct {
        logic [1:0]  func;
        logic [13:0] a_year;
        logic [3:0]  a_month;
        logic [4:0]  a_day;
        logic [13:0] b_year;
        logic [3:0]  b_month;
        logic [4:0]  b_day;
        logic [22:0] offset;
    } date_req_t;

    // Predicts date results and holds them until the block delivers them
    class date_scoreboard;
        logic [48:0] pending[$];
        int mismatches = 0;

        function bit leap(longint y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function longint month_days(longint y, longint m);
            longint t[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            if (m == 2 && leap(y)) return 29;
            return t[m];
        endfunction

        function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q -= 1;
            return q;
        endfunction

        function longint day_number(logic [13:0] yr, logic [3:0] mo, logic [4:0] dy);
            longint y, m, p, n;
            y = yr;
            m = mo;
            p = y - 1;
            // clamp month into 1..12
            if (m < 1) m = 1;
            if (m > 12) m = 12;
            n = 365 * p + fdiv(p, 4) - fdiv(p, 100) + fdiv(p, 400);
            for (longint k = 1; k < m; k++) n += month_days(y, k);
            return n + longint'(dy) - 1;
        endfunction

        function logic [22:0] to_date(longint n);
            longint q400, r, q100, q4, q1, y, m;
            q400 = n / 146097;
            r    = n % 146097;
            q100 = r / 36524;
            if (q100 > 3) q100 = 3;
            r -= q100 * 36524;
            q4 = r / 1461;
            r -= q4 * 1461;
            q1 = r / 365;
            if (q1 > 3) q1 = 3;
            r -= q1 * 365;
            y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
            m = 1;
            while (m < 12 && r >= month_days(y, m)) begin
                r -= month_days(y, m);
                m++;
            end
            return {5'(r + 1), 4'(m), 14'(y)};
        endfunction

        function void note_input(date_req_t q);
            longint n, off, dv;
            logic [48:0] e;
            e = '0;
            off = longint'($signed(q.offset));
            if (q.func == FUNC_ADD || q.func == FUNC_SUB) begin
                n = day_number(q.a_year, q.a_month, q.a_day)
                    + ((q.func == FUNC_ADD) ? off : -off);
                if (n < 0 || n > day_number(14'(YEAR_MAX_DEF), 4'd12, 5'd31))
                    e[48] = 1'b1;
                else
                    e[22:0] = to_date(n);
            end else begin
                dv = day_number(q.a_year, q.a_month, q.a_day)
                     - day_number(q.b_year, q.b_month, q.b_day);
                // saturate the difference
                if (dv > DIFF_LIMIT) dv = DIFF_LIMIT;
                if (dv < -DIFF_LIMIT) dv = -DIFF_LIMIT;
                e[45:23] = 23'(dv);
                e[46] = {q.a_year, q.a_month, q.a_day} > {q.b_year, q.b_month, q.b_day};
                e[47] = {q.a_year, q.a_month, q.a_day} == {q.b_year, q.b_month, q.b_day};
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [55:0] d);
            logic [48:0] e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", d);
                return;
            end
            e = pending.pop_front();
            if (d[13:0] !== e[13:0] || d[17:14] !== e[17:14] || d[22:18] !== e[22:18]
                || d[45:23] !== e[45:23] || d[46] !== e[46] || d[47] !== e[47]
                || d[48] !== e[48] || d[55:49] !== 7'd0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp y%0d m%0d d%0d diff%0d gt%b eq%b oor%b, got %h",
                             e[13:0], e[17:14], e[22:18], $signed(e[45:23]), e[46],
                             e[47], e[48], d);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    date_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 1'b0;

    gregorian_date_arithmetic dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Gap length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (calm || r < 60) return 0;
        if (r < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Count cycles and stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_STOP) begin
            $display("FAIL gregorian_date_arithmetic");
            $finish;
        end
    end

    // Check results and stall the result side at random
    int stall = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (stall > 0) begin
            stall <= stall - 1;
            m_tready <= 1'b0;
        end else begin
            stall <= gap_len();
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(date_req_t q);
        int g;
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, q.offset, q.b_day, q.b_month, q.b_year,
                    q.a_day, q.a_month, q.a_year, q.func};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(q);
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic send(logic [1:0] f, int ay, int am, int ad, int by, int bm, int bd,
                        int off);
        date_req_t q;
        q = '{f, 14'(ay), 4'(am), 5'(ad), 14'(by), 4'(bm), 5'(bd), 23'(off)};
        send_item(q);
    endtask

    // Random date: mostly valid, some with raw out-of-range fields
    task automatic rand_date(output logic [13:0] y, output logic [3:0] m,
                             output logic [4:0] d);
        int dim;
        if ($urandom_range(9) == 0) begin
            y = 14'($urandom);
            m = 4'($urandom);
            d = 5'($urandom);
        end else begin
            y = 14'($urandom_range(YEAR_MAX_DEF, 1));
            m = 4'($urandom_range(12, 1));
            dim = int'(sb.month_days(y, m));
            d = 5'($urandom_range(dim, 1));
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    initial begin
        date_req_t q;
        int r;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: boundaries, leap rules, raw fields, saturation
        send(FUNC_ADD, 1, 1, 1, 1, 1, 1, 0);
        send(FUNC_SUB, 1, 1, 1, 1, 1, 1, 1);
        send(FUNC_ADD, 9999, 12, 31, 1, 1, 1, 1);
        send(FUNC_ADD, 9999, 12, 31, 1, 1, 1, 0);
        send(FUNC_ADD, 2000, 2, 28, 1, 1, 1, 1);
        send(FUNC_ADD, 1900, 2, 28, 1, 1, 1, 1);
        send(FUNC_ADD, 2024, 2, 29, 1, 1, 1, 365);
        send(FUNC_ADD, 1, 1, 1, 1, 1, 1, 4194303);
        send(FUNC_SUB, 1, 1, 1, 1, 1, 1, -4194304);
        send(FUNC_ADD, 9999, 12, 31, 1, 1, 1, -4194304);
        send(FUNC_SUB, 5000, 6, 15, 1, 1, 1, 4194303);
        send(FUNC_CMP, 2020, 5, 5, 2020, 5, 5, 0);
        send(FUNC_CMP, 2021, 1, 1, 2020, 12, 31, 0);
        send(FUNC_CMP, 2020, 12, 31, 2021, 1, 1, 0);
        send(FUNC_CMP3, 2020, 3, 1, 2020, 2, 29, 0);
        send(FUNC_ADD, 2001, 0, 10, 1, 1, 1, 3);
        send(FUNC_ADD, 2001, 15, 31, 1, 1, 1, 3);
        send(FUNC_ADD, 2001, 3, 0, 1, 1, 1, 0);
        send(FUNC_ADD, 2001, 2, 31, 1, 1, 1, 0);
        send(FUNC_CMP, 0, 1, 1, 1, 1, 1, 0);
        send(FUNC_CMP, 16383, 15, 31, 0, 0, 0, 0);
        send(FUNC_CMP, 0, 0, 0, 16383, 15, 31, 0);
        send(FUNC_ADD, 16383, 1, 1, 1, 1, 1, -3000000);
        send(FUNC_SUB, 0, 1, 1, 1, 1, 1, -400);
        wait_drain();

        // Random: a calm stretch first, then idling on both sides
        for (int i = 0; i < N_RANDOM; i++) begin
            calm = (i < 80);
            r = $urandom_range(99);
            q.func = (r < 40) ? FUNC_ADD : (r < 70) ? FUNC_SUB :
                     (r < 95) ? FUNC_CMP : FUNC_CMP3;
            rand_date(q.a_year, q.a_month, q.a_day);
            rand_date(q.b_year, q.b_month, q.b_day);
            r = $urandom_range(9);
            if (r < 4)      q.offset = 23'($signed($urandom_range(2000)) - 1000);
            else if (r < 8) q.offset = 23'($signed($urandom_range(2000000)) - 1000000);
            else            q.offset = 23'($urandom);
            // close dates so compare hits equal and near orderings
            if (q.func[1] && $urandom_range(3) == 0) begin
                q.b_year = q.a_year;
                if ($urandom_range(1)) q.b_month = q.a_month;
                if ($urandom_range(1)) q.b_day = q.a_day;
            end
            send_item(q);
            if (i == 400) wait_drain();
        end
        wait_drain();

        if (sb.mismatches == 0)
            $display("PASS gregorian_date_arithmetic");
        else
            $display("FAIL gregorian_date_arithmetic");
        $finish;
    end
endmodule

### sim.f
sv/gda_pkg.sv
sv/gda_serial.sv
sv/gda_date.sv
sv/gregorian_date_arithmetic.sv
tb/sv/gregorian_date_arithmetic_tb.sv
